FILE: sv/hbf_pkg.sv
// hbf_pkg: shared types, codes and helpers for the height-map box placer
// used by hbf_ctrl, hbf_dp and heightmap_best_fit_box_placer
package hbf_pkg;

    localparam int ZW = 17;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_PLACE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] ST_PREF    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_LOADED  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DEPTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] pos_z;
        logic [6:0] size_x;
        logic [6:0] size_y;
        logic [7:0] size_z;
        logic       pref_given;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] start_x;
        logic [6:0] start_y;
        logic [7:0] start_z;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [8:0] end_z;
    } t_out;

    typedef struct packed {
        logic [6:0] sx;
        logic [6:0] sy;
        logic [7:0] sz;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [8:0] ez;
    } t_box;

    typedef enum logic [1:0] {
        W_REST  = 2'd0,
        W_WASTE = 2'd1,
        W_RAISE = 2'd2
    } t_walk;

    typedef struct packed {
        logic       load_in;
        logic       clr_start;
        logic       srch_init;
        logic       x_adv;
        logic       y_adv;
        logic       walk_start;
        t_walk      walk_mode;
        logic       ovl_start;
        logic       cand_box;
        logic       best_take;
        logic       append;
        logic       app_best;
        logic       res_load;
        logic       res_box;
        logic [2:0] res_code;
    } t_cmd;

    typedef struct packed {
        logic       clr_busy;
        logic       walk_busy;
        logic       ovl_busy;
        logic       hit;
        logic       full;
        logic [1:0] func;
        logic       pref;
        logic       x_ok;
        logic       y_ok;
        logic       cb_inb;
        logic       better;
        logic       waste_zero;
        logic       found;
        logic       out_free;
    } t_sts;

    // w / 10 by reciprocal, exact for 7-bit values, at least 1
    function automatic logic [6:0] f_step(input logic [6:0] w);
        logic [17:0] p;
        logic [6:0]  q;
        begin
            p = 18'(w) * 18'd205;
            q = p[17:11];
            f_step = (q == 7'd0) ? 7'd1 : q;
        end
    endfunction

endpackage

FILE: sv/hbf_ctrl.sv
// hbf_ctrl: sequencing state machine of the box placer
// depends on hbf_pkg; drives hbf_dp through t_cmd, watches t_sts
module hbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hbf_pkg::t_sts i_sts,
    output hbf_pkg::t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DEC   = 13'b0000000000100,
        S_PREF  = 13'b0000000001000,
        S_CAND  = 13'b0000000010000,
        S_REST  = 13'b0000000100000,
        S_CHK   = 13'b0000001000000,
        S_OVL   = 13'b0000010000000,
        S_WASTE = 13'b0000100000000,
        S_NEXT  = 13'b0001000000000,
        S_FIN   = 13'b0010000000000,
        S_RAISE = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_code, n_code;
    logic       r_box, n_box;
    logic       r_clr_res, n_clr_res;
    logic       r_rstart, n_rstart;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_code    = r_code;
        n_box     = r_box;
        n_clr_res = r_clr_res;
        n_rstart  = 1'b0;
        o_cmd     = '0;
        o_cmd.walk_mode = hbf_pkg::W_REST;
        if (r_rstart) begin
            o_cmd.walk_start = 1'b1;
            o_cmd.walk_mode  = hbf_pkg::W_RAISE;
        end
        case (r_state)
            S_CLR: begin
                if (!i_sts.clr_busy) begin
                    if (r_clr_res) begin
                        n_clr_res = 1'b0;
                        n_code    = hbf_pkg::ST_CLEARED;
                        n_box     = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.func == hbf_pkg::FUNC_CLEAR) begin
                    o_cmd.clr_start = 1'b1;
                    n_clr_res = 1'b1;
                    n_state   = S_CLR;
                end else if (i_sts.func != hbf_pkg::FUNC_LOAD &&
                             i_sts.func != hbf_pkg::FUNC_PLACE) begin
                    n_code  = hbf_pkg::ST_NOFIT;
                    n_box   = 1'b0;
                    n_state = S_DONE;
                end else if (i_sts.full) begin
                    n_code  = hbf_pkg::ST_FULL;
                    n_box   = 1'b0;
                    n_state = S_DONE;
                end else if (i_sts.func == hbf_pkg::FUNC_LOAD) begin
                    o_cmd.append = 1'b1;
                    n_code   = hbf_pkg::ST_LOADED;
                    n_box    = 1'b1;
                    n_rstart = 1'b1;
                    n_state  = S_RAISE;
                end else if (i_sts.pref) begin
                    o_cmd.ovl_start = 1'b1;
                    n_state = S_PREF;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state = S_CAND;
                end
            end
            S_PREF: begin
                if (!i_sts.ovl_busy) begin
                    if (i_sts.cb_inb && !i_sts.hit) begin
                        o_cmd.append = 1'b1;
                        n_code   = hbf_pkg::ST_PREF;
                        n_box    = 1'b1;
                        n_rstart = 1'b1;
                        n_state  = S_RAISE;
                    end else begin
                        o_cmd.srch_init = 1'b1;
                        n_state = S_CAND;
                    end
                end
            end
            S_CAND: begin
                if (!i_sts.y_ok) begin
                    if (i_sts.found) begin
                        n_state = S_FIN;
                    end else begin
                        n_code  = hbf_pkg::ST_NOFIT;
                        n_box   = 1'b0;
                        n_state = S_DONE;
                    end
                end else if (!i_sts.x_ok) begin
                    o_cmd.y_adv = 1'b1;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.walk_mode  = hbf_pkg::W_REST;
                    n_state = S_REST;
                end
            end
            S_REST: begin
                if (!i_sts.walk_busy) begin
                    o_cmd.cand_box = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.cb_inb) begin
                    o_cmd.x_adv = 1'b1;
                    n_state = S_CAND;
                end else begin
                    o_cmd.ovl_start = 1'b1;
                    n_state = S_OVL;
                end
            end
            S_OVL: begin
                if (!i_sts.ovl_busy) begin
                    if (i_sts.hit) begin
                        o_cmd.x_adv = 1'b1;
                        n_state = S_CAND;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        o_cmd.walk_mode  = hbf_pkg::W_WASTE;
                        n_state = S_WASTE;
                    end
                end
            end
            S_WASTE: begin
                if (!i_sts.walk_busy) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.better) begin
                    o_cmd.best_take = 1'b1;
                end
                if (i_sts.better && i_sts.waste_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.x_adv = 1'b1;
                    n_state = S_CAND;
                end
            end
            S_FIN: begin
                o_cmd.append   = 1'b1;
                o_cmd.app_best = 1'b1;
                n_code   = hbf_pkg::ST_SEARCH;
                n_box    = 1'b1;
                n_rstart = 1'b1;
                n_state  = S_RAISE;
            end
            S_RAISE: begin
                if (!r_rstart && !i_sts.walk_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_box  = r_box;
                    o_cmd.res_code = r_code;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_res <= 1'b0;
            r_rstart  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_res <= n_clr_res;
            r_rstart  <= n_rstart;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_box  <= n_box;
    end

endmodule

FILE: sv/hbf_dp.sv
// hbf_dp: datapath of the box placer: height map, placement table,
// footprint walker, overlap scanner, search registers; depends on hbf_pkg
module hbf_dp #(
    parameter int GRID_SIZE      = 64,
    parameter int MAX_PLACEMENTS = 64,
    parameter int HEIGHT_MAX     = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  hbf_pkg::t_in  i_item,
    input  hbf_pkg::t_cmd i_cmd,
    output hbf_pkg::t_sts o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output hbf_pkg::t_out o_out
);

    localparam int HW    = $clog2(HEIGHT_MAX + 1);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TIW   = (MAX_PLACEMENTS > 1) ? $clog2(MAX_PLACEMENTS) : 1;
    localparam int CW    = $clog2(MAX_PLACEMENTS + 1);
    localparam int WW    = HW + 14;
    localparam int ZW    = hbf_pkg::ZW;

    // configuration
    logic [6:0] r_bw, r_bd;
    logic [7:0] r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= 7'd64;
            r_bd <= 7'd64;
            r_bh <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hbf_pkg::CFG_WIDTH:  r_bw <= i_cfg_data[6:0];
                hbf_pkg::CFG_DEPTH:  r_bd <= i_cfg_data[6:0];
                hbf_pkg::CFG_HEIGHT: r_bh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hbf_pkg::t_in  r_in;
    hbf_pkg::t_box r_cb, r_best, r_ap, r_tab_rd;
    logic [ZW-1:0] r_cez;
    logic [6:0]    r_xs, r_ys;
    logic [7:0]    r_x, r_y;
    logic [HW-1:0] r_rest, r_rh, r_hm_rd;
    logic [WW-1:0] r_waste, r_bestw;
    logic          r_found;
    logic [CW-1:0] r_cnt;

    logic          r_wk_act, r_p_v, r_p_in;
    hbf_pkg::t_walk r_wk_mode;
    logic [7:0]    r_bx, r_by, r_sx, r_sy, r_dx, r_dy;
    logic [AW-1:0] r_p_addr;

    logic          r_clr_act;
    logic [AW-1:0] r_clr_addr;

    logic          r_ov_act, r_ov_pv, r_hit;
    logic [CW-1:0] r_ov_i;

    logic          r_out_v;
    hbf_pkg::t_out r_out;

    logic [HW-1:0] hm [DEPTH];
    hbf_pkg::t_box tab [MAX_PLACEMENTS];

    // walker issue side
    logic [8:0]    wk_x, wk_y;
    logic          wk_in;
    logic [AW-1:0] wk_addr;
    logic          wk_last;
    logic [HW-1:0] wk_c;

    assign wk_x    = {1'b0, r_bx} + {1'b0, r_dx};
    assign wk_y    = {1'b0, r_by} + {1'b0, r_dy};
    assign wk_in   = (32'(wk_x) < 32'(GRID_SIZE)) && (32'(wk_y) < 32'(GRID_SIZE));
    assign wk_addr = AW'(32'(wk_y) * 32'(GRID_SIZE) + 32'(wk_x));
    assign wk_last = (r_dx == r_sx - 8'd1) && (r_dy == r_sy - 8'd1);
    assign wk_c    = r_p_in ? r_hm_rd : '0;

    // walker start values
    logic [7:0] st_bx, st_by, st_sx, st_sy;
    always_comb begin
        if (i_cmd.walk_mode == hbf_pkg::W_RAISE) begin
            st_bx = {1'b0, r_ap.sx};
            st_by = {1'b0, r_ap.sy};
            st_sx = r_ap.ex - {1'b0, r_ap.sx};
            st_sy = r_ap.ey - {1'b0, r_ap.sy};
        end else begin
            st_bx = r_x;
            st_by = r_y;
            st_sx = {1'b0, r_in.size_x};
            st_sy = {1'b0, r_in.size_y};
        end
    end

    // height map writes
    logic          hm_we;
    logic [AW-1:0] hm_waddr;
    logic [HW-1:0] hm_wdata;
    always_comb begin
        hm_we    = 1'b0;
        hm_waddr = r_p_addr;
        hm_wdata = r_rh;
        if (r_clr_act) begin
            hm_we    = 1'b1;
            hm_waddr = r_clr_addr;
            hm_wdata = '0;
        end else if (r_p_v && r_wk_mode == hbf_pkg::W_RAISE && r_p_in && r_hm_rd < r_rh) begin
            hm_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hm_we) begin
            hm[hm_waddr] <= hm_wdata;
        end
        if (r_wk_act) begin
            r_hm_rd <= hm[wk_addr];
        end
    end

    // placement table
    hbf_pkg::t_box ap_src;
    assign ap_src = i_cmd.app_best ? r_best : r_cb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            tab[r_cnt[TIW-1:0]] <= ap_src;
        end
        if (r_ov_act) begin
            r_tab_rd <= tab[r_ov_i[TIW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_wk_act   <= 1'b0;
            r_p_v      <= 1'b0;
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
            r_ov_act   <= 1'b0;
            r_ov_pv    <= 1'b0;
            r_out_v    <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.clr_start) begin
                r_cnt      <= '0;
                r_clr_act  <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_act) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_act <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.append) begin
                r_cnt <= r_cnt + 1'b1;
            end

            r_p_v <= r_wk_act;
            if (i_cmd.walk_start) begin
                r_wk_act <= (st_sx != 8'd0) && (st_sy != 8'd0);
            end else if (r_wk_act && wk_last) begin
                r_wk_act <= 1'b0;
            end

            r_ov_pv <= r_ov_act;
            if (i_cmd.ovl_start) begin
                r_ov_act <= (r_cnt != '0);
            end else if (r_ov_act && (r_ov_i == r_cnt - 1'b1)) begin
                r_ov_act <= 1'b0;
            end

            if (i_cmd.srch_init) begin
                r_found <= 1'b0;
            end else if (i_cmd.best_take) begin
                r_found <= 1'b1;
            end

            if (i_cmd.res_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in        <= i_item;
            r_xs        <= hbf_pkg::f_step(i_item.size_x);
            r_ys        <= hbf_pkg::f_step(i_item.size_y);
            r_cb.sx     <= i_item.pos_x;
            r_cb.sy     <= i_item.pos_y;
            r_cb.sz     <= i_item.pos_z;
            r_cb.ex     <= {1'b0, i_item.pos_x} + {1'b0, i_item.size_x};
            r_cb.ey     <= {1'b0, i_item.pos_y} + {1'b0, i_item.size_y};
            r_cb.ez     <= {1'b0, i_item.pos_z} + {1'b0, i_item.size_z};
            r_cez       <= ZW'({1'b0, i_item.pos_z} + {1'b0, i_item.size_z});
        end else if (i_cmd.cand_box) begin
            r_cb.sx     <= r_x[6:0];
            r_cb.sy     <= r_y[6:0];
            r_cb.sz     <= 8'(r_rest);
            r_cb.ex     <= r_x + {1'b0, r_in.size_x};
            r_cb.ey     <= r_y + {1'b0, r_in.size_y};
            r_cb.ez     <= 9'(ZW'(r_rest) + ZW'(r_in.size_z));
            r_cez       <= ZW'(r_rest) + ZW'(r_in.size_z);
        end

        if (i_cmd.srch_init) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.y_adv) begin
            r_x <= '0;
            r_y <= r_y + {1'b0, r_ys};
        end else if (i_cmd.x_adv) begin
            r_x <= r_x + {1'b0, r_xs};
        end

        if (i_cmd.best_take) begin
            r_best  <= r_cb;
            r_bestw <= r_waste;
        end

        if (i_cmd.append) begin
            r_ap <= ap_src;
            if (32'(ap_src.ez) > 32'(HEIGHT_MAX)) begin
                r_rh <= HW'(HEIGHT_MAX);
            end else begin
                r_rh <= HW'(ap_src.ez);
            end
        end

        if (i_cmd.walk_start) begin
            r_wk_mode <= i_cmd.walk_mode;
            r_bx      <= st_bx;
            r_by      <= st_by;
            r_sx      <= st_sx;
            r_sy      <= st_sy;
            r_dx      <= '0;
            r_dy      <= '0;
            if (i_cmd.walk_mode == hbf_pkg::W_REST) begin
                r_rest <= '0;
            end
            if (i_cmd.walk_mode == hbf_pkg::W_WASTE) begin
                r_waste <= '0;
            end
        end else begin
            if (r_wk_act) begin
                if (r_dx == r_sx - 8'd1) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 8'd1;
                end else begin
                    r_dx <= r_dx + 8'd1;
                end
            end
            if (r_p_v && r_wk_mode == hbf_pkg::W_REST && wk_c > r_rest) begin
                r_rest <= wk_c;
            end
            if (r_p_v && r_wk_mode == hbf_pkg::W_WASTE) begin
                r_waste <= r_waste + WW'(r_rest - wk_c);
            end
        end
        r_p_in   <= wk_in;
        r_p_addr <= wk_addr;

        if (i_cmd.ovl_start) begin
            r_ov_i <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (r_ov_act) begin
                r_ov_i <= r_ov_i + 1'b1;
            end
            if (r_ov_pv && !(r_cb.ex <= {1'b0, r_tab_rd.sx} ||
                             {1'b0, r_cb.sx} >= r_tab_rd.ex ||
                             r_cb.ey <= {1'b0, r_tab_rd.sy} ||
                             {1'b0, r_cb.sy} >= r_tab_rd.ey ||
                             r_cb.ez <= {1'b0, r_tab_rd.sz} ||
                             {1'b0, r_cb.sz} >= r_tab_rd.ez)) begin
                r_hit <= 1'b1;
            end
        end

        if (i_cmd.res_load) begin
            r_out.status <= i_cmd.res_code;
            if (i_cmd.res_box) begin
                r_out.start_x <= r_ap.sx;
                r_out.start_y <= r_ap.sy;
                r_out.start_z <= r_ap.sz;
                r_out.end_x   <= r_ap.ex;
                r_out.end_y   <= r_ap.ey;
                r_out.end_z   <= r_ap.ez;
            end else begin
                r_out.start_x <= '0;
                r_out.start_y <= '0;
                r_out.start_z <= '0;
                r_out.end_x   <= '0;
                r_out.end_y   <= '0;
                r_out.end_z   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_comb begin
        o_sts.clr_busy   = r_clr_act;
        o_sts.walk_busy  = r_wk_act || r_p_v;
        o_sts.ovl_busy   = r_ov_act || r_ov_pv;
        o_sts.hit        = r_hit;
        o_sts.full       = (32'(r_cnt) >= 32'(MAX_PLACEMENTS));
        o_sts.func       = r_in.func;
        o_sts.pref       = r_in.pref_given;
        o_sts.x_ok       = ({1'b0, r_x} + {2'b0, r_in.size_x}) <= {2'b0, r_bw};
        o_sts.y_ok       = ({1'b0, r_y} + {2'b0, r_in.size_y}) <= {2'b0, r_bd};
        o_sts.cb_inb     = (r_cb.ex <= {1'b0, r_bw}) && (r_cb.ey <= {1'b0, r_bd}) &&
                           (r_cez <= ZW'(r_bh));
        o_sts.better     = !r_found || (r_waste < r_bestw);
        o_sts.waste_zero = (r_waste == '0);
        o_sts.found      = r_found;
        o_sts.out_free   = !r_out_v || !i_out_stall;
    end

endmodule

FILE: sv/heightmap_best_fit_box_placer.sv
// Height-map best-fit box placer. One item is handled at a time. After reset,
// and for every clear command, the height map is swept one cell per cycle
// while no item is taken. A load appends the box to the placement table, then
// walks its footprint to raise the map and loads the result. A place checks a
// given preferred corner against the bounds and all placements, then for each
// scanned candidate walks the footprint for the rest height, checks bounds,
// scans the placements for overlap and walks the footprint for the waste, and
// finally raises the map and loads the result. Map cells and table entries are
// read one per cycle. A finished result waits in an output register.
// top level: joins hbf_ctrl and hbf_dp; depends on hbf_pkg
module heightmap_best_fit_box_placer #(
    parameter int GRID_SIZE      = 64,
    parameter int MAX_PLACEMENTS = 64,
    parameter int HEIGHT_MAX     = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hbf_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hbf_pkg::t_out o_out
);

    hbf_pkg::t_cmd cmd;
    hbf_pkg::t_sts sts;

    hbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hbf_dp #(
        .GRID_SIZE      (GRID_SIZE),
        .MAX_PLACEMENTS (MAX_PLACEMENTS),
        .HEIGHT_MAX     (HEIGHT_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
